// ----- hdl/xelp_pkg.sv -----
// shared types, constants and the per-kind field programmes for the
// entry list reply parser; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package xelp_pkg;

    localparam int unsigned MAX_ENTRIES = 4096;

    // header layout
    localparam logic [31:0] HDR_ERR_POS  = 32'd31;
    localparam logic [31:0] HDR_CNT_POS  = 32'd32;
    localparam logic [31:0] HDR_LAST_POS = 32'd35;

    localparam logic [3:0] WORD_LEN = 4'd4;
    localparam logic [3:0] TIME_LEN = 4'd8;

    // configuration register indexes
    localparam logic [1:0] CFG_DOMAIN   = 2'd0;
    localparam logic [1:0] CFG_VARIABLE = 2'd1;
    localparam logic [1:0] CFG_LINK     = 2'd2;

    // entry kinds
    localparam logic [1:0] EK_DOMAIN   = 2'd0;
    localparam logic [1:0] EK_VARIABLE = 2'd1;
    localparam logic [1:0] EK_LINK     = 2'd2;

    typedef enum logic [2:0] {
        RK_ID_BYTE   = 3'd0,
        RK_EMPTY_ID  = 3'd1,
        RK_DONE      = 3'd2,
        RK_SRV_ERROR = 3'd3,
        RK_UNKNOWN   = 3'd4,
        RK_TOO_MANY  = 3'd5
    } t_rkind;

    typedef enum logic [2:0] {
        OP_END     = 3'd0,
        OP_FIX4    = 3'd1,
        OP_FIX8    = 3'd2,
        OP_SKIPSTR = 3'd3,
        OP_IDSTR   = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_TYPE   = 4'b0100,
        PH_STEP   = 4'b1000
    } t_phase;

    typedef struct packed {
        t_rkind      kind;
        logic [7:0]  data_byte;
        logic [11:0] entry_index;
        logic [1:0]  entry_kind;
        logic        last;
        logic [12:0] entry_total;
    } t_result;

    localparam t_op PROG_DOMAIN [8] = '{
        OP_SKIPSTR, OP_IDSTR, OP_FIX8, OP_SKIPSTR, OP_FIX8, OP_END, OP_END, OP_END
    };
    localparam t_op PROG_VARIABLE [8] = '{
        OP_SKIPSTR, OP_FIX4, OP_IDSTR, OP_FIX8, OP_SKIPSTR, OP_FIX8, OP_END, OP_END
    };
    localparam t_op PROG_LINK [8] = '{
        OP_FIX4, OP_SKIPSTR, OP_SKIPSTR, OP_IDSTR, OP_FIX8, OP_SKIPSTR, OP_FIX8, OP_END
    };

    function automatic t_op prog_op(input logic [1:0] kind, input logic [2:0] step);
        t_op op;
        unique case (kind)
            EK_DOMAIN:   op = PROG_DOMAIN[step];
            EK_VARIABLE: op = PROG_VARIABLE[step];
            EK_LINK:     op = PROG_LINK[step];
            default:     op = OP_END;
        endcase
        return op;
    endfunction

    // byte count of the field that a step opens with
    function automatic logic [3:0] step_len(input t_op op);
        return (op == OP_FIX8) ? TIME_LEN : WORD_LEN;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/xelp_ifs.sv -----
// channel interfaces of the entry list reply parser: reply bytes in,
// results out, register writes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface xelp_reply_if;
    logic       valid;
    logic       ready;
    logic [7:0] reply_byte;
    logic       start_of_reply;
    modport source (output valid, reply_byte, start_of_reply, input ready);
    modport sink   (input valid, reply_byte, start_of_reply, output ready);
endinterface

interface xelp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [7:0]  data_byte;
    logic [11:0] entry_index;
    logic [1:0]  entry_kind;
    logic        last_of_identifier;
    logic [12:0] entry_total;
    modport source (output valid, result_kind, data_byte, entry_index, entry_kind,
                    last_of_identifier, entry_total, input ready);
    modport sink   (input valid, result_kind, data_byte, entry_index, entry_kind,
                    last_of_identifier, entry_total, output ready);
endinterface

interface xelp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [31:0] wr_data;
    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ----- hdl/xdr_entry_list_reply_parser.sv -----
// top level of the xdr entry list reply parser
// depends on xelp_pkg and the channel interfaces in xelp_ifs.sv
// a result word is registered from the reply byte that causes it, into the output word or the skid word
// throughput: one reply byte per cycle while the skid word is empty; the byte walk is counters and one compare
// a two-deep result buffer keeps input ready high while a result waits
// reset (synchronous): parser idle, buffer empty, type codes back to 1, 2 and 8
`timescale 1ns / 1ps
`default_nettype none

module xdr_entry_list_reply_parser (
    input  wire            i_clk,
    input  wire            i_rst_n,
    xelp_reply_if.sink     i_reply,
    xelp_result_if.source  o_result,
    xelp_cfg_if.sink       i_cfg
);

    // configuration
    logic [31:0] r_domain_code;
    logic [31:0] r_variable_code;
    logic [31:0] r_link_code;

    // parser state
    xelp_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_step, n_step;
    logic [1:0]  r_kind, n_kind;
    logic [1:0]  r_olb, n_olb;
    logic [31:0] r_word, n_word;
    logic [3:0]  r_field, n_field;
    logic [31:0] r_str, n_str;
    logic [12:0] r_entry, n_entry;
    logic [12:0] r_total, n_total;

    // result buffer
    xelp_pkg::t_result r_out, r_skid, n_res;
    logic r_out_valid, r_skid_valid, n_res_valid;

    logic w_in_acc, w_out_take;
    xelp_pkg::t_phase s_phase;
    logic [31:0] s_str, s_word, w_gathered, w_count;
    logic [1:0]  s_olb, w_olb_inc;
    logic [3:0]  w_fdec;
    logic [31:0] w_sdec;
    xelp_pkg::t_op w_op, w_ns_op, w_first_op;
    logic [2:0]  w_ns_step;
    logic [12:0] w_entry_inc;
    logic [1:0]  w_match_kind;
    logic        w_match;
    logic        w_do_next;

    assign w_in_acc   = i_reply.valid && i_reply.ready;
    assign w_out_take = o_result.valid && o_result.ready;
    assign i_reply.ready = !r_skid_valid;
    assign i_cfg.ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_domain_code   <= 32'd1;
            r_variable_code <= 32'd2;
            r_link_code     <= 32'd8;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                xelp_pkg::CFG_DOMAIN:   r_domain_code   <= i_cfg.wr_data;
                xelp_pkg::CFG_VARIABLE: r_variable_code <= i_cfg.wr_data;
                xelp_pkg::CFG_LINK:     r_link_code     <= i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    // start of reply overrides the header tracking before the byte is used
    assign s_phase    = (i_reply.start_of_reply) ? xelp_pkg::PH_HEADER : r_phase;
    assign s_str      = (i_reply.start_of_reply) ? 32'd0 : r_str;
    assign s_olb      = (i_reply.start_of_reply) ? 2'd0 : r_olb;
    assign s_word     = (i_reply.start_of_reply) ? 32'd0 : r_word;
    assign w_gathered = {s_word[23:0], i_reply.reply_byte};
    assign w_count    = w_gathered;
    assign w_olb_inc  = s_olb + 2'd1;
    assign w_fdec     = (r_field != 4'd0) ? r_field - 4'd1 : 4'd0;
    assign w_sdec     = r_str - 32'd1;

    assign w_op        = xelp_pkg::prog_op(r_kind, r_step);
    assign w_ns_step   = r_step + 3'd1;
    assign w_ns_op     = xelp_pkg::prog_op(r_kind, w_ns_step);
    assign w_entry_inc = r_entry + 13'd1;

    // type word decode, earlier codes win
    always_comb begin
        w_match      = 1'b1;
        w_match_kind = xelp_pkg::EK_DOMAIN;
        priority if (w_gathered == r_domain_code) w_match_kind = xelp_pkg::EK_DOMAIN;
        else if (w_gathered == r_variable_code)   w_match_kind = xelp_pkg::EK_VARIABLE;
        else if (w_gathered == r_link_code)       w_match_kind = xelp_pkg::EK_LINK;
        else w_match = 1'b0;
    end
    assign w_first_op = xelp_pkg::prog_op(w_match_kind, 3'd0);

    always_comb begin
        n_phase     = r_phase;
        n_step      = r_step;
        n_kind      = r_kind;
        n_olb       = r_olb;
        n_word      = r_word;
        n_field     = r_field;
        n_str       = r_str;
        n_entry     = r_entry;
        n_total     = r_total;
        n_res       = '0;
        n_res_valid = 1'b0;
        w_do_next   = 1'b0;

        if (w_in_acc) begin
            n_phase = s_phase;
            n_str   = s_str;
            n_olb   = s_olb;
            n_word  = s_word;
            if (s_phase != xelp_pkg::PH_IDLE) begin
                n_olb = w_olb_inc;
                unique case (s_phase)
                    xelp_pkg::PH_HEADER: begin
                        if (s_str == xelp_pkg::HDR_ERR_POS && i_reply.reply_byte != 8'd0) begin
                            n_phase         = xelp_pkg::PH_IDLE;
                            n_res_valid     = 1'b1;
                            n_res.kind      = xelp_pkg::RK_SRV_ERROR;
                            n_res.data_byte = i_reply.reply_byte;
                        end else begin
                            if (s_str >= xelp_pkg::HDR_CNT_POS) n_word = w_gathered;
                            if (s_str >= xelp_pkg::HDR_LAST_POS) begin
                                n_str = 32'd0;
                                if (w_count > 32'(xelp_pkg::MAX_ENTRIES)) begin
                                    n_phase     = xelp_pkg::PH_IDLE;
                                    n_res_valid = 1'b1;
                                    n_res.kind  = xelp_pkg::RK_TOO_MANY;
                                end else begin
                                    n_total = w_count[12:0];
                                    n_entry = 13'd0;
                                    if (w_count == 32'd0) begin
                                        n_phase     = xelp_pkg::PH_IDLE;
                                        n_res_valid = 1'b1;
                                        n_res.kind  = xelp_pkg::RK_DONE;
                                    end else begin
                                        n_phase = xelp_pkg::PH_TYPE;
                                        n_field = xelp_pkg::WORD_LEN;
                                    end
                                end
                            end else begin
                                n_str = s_str + 32'd1;
                            end
                        end
                    end
                    xelp_pkg::PH_TYPE: begin
                        n_word  = w_gathered;
                        n_field = w_fdec;
                        if (w_fdec == 4'd0) begin
                            if (w_match) begin
                                n_kind  = w_match_kind;
                                n_phase = xelp_pkg::PH_STEP;
                                n_step  = 3'd0;
                                n_field = xelp_pkg::step_len(w_first_op);
                                n_str   = 32'd0;
                            end else begin
                                n_phase           = xelp_pkg::PH_IDLE;
                                n_res_valid       = 1'b1;
                                n_res.kind        = xelp_pkg::RK_UNKNOWN;
                                n_res.entry_index = r_entry[11:0];
                            end
                        end
                    end
                    xelp_pkg::PH_STEP: begin
                        unique case (w_op)
                            xelp_pkg::OP_FIX4, xelp_pkg::OP_FIX8: begin
                                n_field = w_fdec;
                                if (w_fdec == 4'd0) w_do_next = 1'b1;
                            end
                            xelp_pkg::OP_END: n_phase = xelp_pkg::PH_IDLE;
                            default: begin
                                // length word, then string bytes, then padding
                                if (r_field != 4'd0) begin
                                    n_word  = w_gathered;
                                    n_field = w_fdec;
                                    if (w_fdec == 4'd0) begin
                                        if (w_gathered == 32'd0) begin
                                            if (w_op == xelp_pkg::OP_IDSTR) begin
                                                n_res_valid       = 1'b1;
                                                n_res.kind        = xelp_pkg::RK_EMPTY_ID;
                                                n_res.entry_index = r_entry[11:0];
                                                n_res.entry_kind  = r_kind;
                                            end
                                            w_do_next = 1'b1;
                                        end else begin
                                            n_str = w_gathered;
                                        end
                                    end
                                end else if (r_str != 32'd0) begin
                                    n_str = w_sdec;
                                    if (w_op == xelp_pkg::OP_IDSTR) begin
                                        n_res_valid       = 1'b1;
                                        n_res.kind        = xelp_pkg::RK_ID_BYTE;
                                        n_res.data_byte   = i_reply.reply_byte;
                                        n_res.entry_index = r_entry[11:0];
                                        n_res.entry_kind  = r_kind;
                                        n_res.last        = (w_sdec == 32'd0);
                                    end
                                    if (w_sdec == 32'd0 && w_olb_inc == 2'd0) w_do_next = 1'b1;
                                end else if (w_olb_inc == 2'd0) begin
                                    w_do_next = 1'b1;
                                end
                            end
                        endcase
                    end
                    default: ;
                endcase
            end
        end

        // move to the next field, or at the end of a programme to the next entry or, after the last one, to idle
        if (w_do_next) begin
            if (w_ns_op == xelp_pkg::OP_END) begin
                n_entry = w_entry_inc;
                if (w_entry_inc >= r_total) begin
                    n_phase = xelp_pkg::PH_IDLE;
                    if (!n_res_valid) begin
                        n_res_valid       = 1'b1;
                        n_res.kind        = xelp_pkg::RK_DONE;
                        n_res.entry_total = r_total;
                    end
                end else begin
                    n_phase = xelp_pkg::PH_TYPE;
                    n_field = xelp_pkg::WORD_LEN;
                end
            end else begin
                n_step  = w_ns_step;
                n_field = xelp_pkg::step_len(w_ns_op);
                n_str   = 32'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= xelp_pkg::PH_IDLE;
            r_step  <= 3'd0;
            r_kind  <= xelp_pkg::EK_DOMAIN;
            r_olb   <= 2'd0;
            r_word  <= 32'd0;
            r_field <= 4'd0;
            r_str   <= 32'd0;
            r_entry <= 13'd0;
            r_total <= 13'd0;
        end else begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_kind  <= n_kind;
            r_olb   <= n_olb;
            r_word  <= n_word;
            r_field <= n_field;
            r_str   <= n_str;
            r_entry <= n_entry;
            r_total <= n_total;
        end
    end

    // result buffer: output word plus one skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (n_res_valid) begin
            if (!r_out_valid || w_out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_res_valid) begin
            if (!r_out_valid || w_out_take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end else if (w_out_take) begin
            r_out <= r_skid;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.result_kind        = r_out.kind;
    assign o_result.data_byte          = r_out.data_byte;
    assign o_result.entry_index        = r_out.entry_index;
    assign o_result.entry_kind         = r_out.entry_kind;
    assign o_result.last_of_identifier = r_out.last;
    assign o_result.entry_total        = r_out.entry_total;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output word");

    a_step_has_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == xelp_pkg::PH_STEP) |-> (w_op != xelp_pkg::OP_END))
        else $error("parser parked on the end of a field programme");

    a_entry_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == xelp_pkg::PH_TYPE || r_phase == xelp_pkg::PH_STEP) |-> (r_entry < r_total))
        else $error("entry walk past the announced count");

    a_kind_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == xelp_pkg::PH_STEP) |-> (r_kind != 2'd3))
        else $error("field walk with no entry kind");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_res_valid && r_out_valid && !w_out_take) |-> !r_skid_valid)
        else $error("result word with a full buffer");

endmodule

`default_nettype wire
